// ===== hw/rtl/csdp_pkg.sv =====
// shared types, constants and packing helper for the divider planner
`default_nettype none

package csdp_pkg;

  // fractional denominator of the pll multiplier, 2^20 - 1
  localparam logic [19:0] FracDen = 20'hFFFFF;

  // configuration register indexes
  localparam logic RegXtal = 1'b0;
  localparam logic RegVco  = 1'b1;

  // status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChan = 2'd1;
  localparam logic [1:0] StatusBadDiv  = 2'd2;

  // per channel constants
  localparam logic [5:0] PllBaseA = 6'd26;
  localparam logic [5:0] PllBaseB = 6'd34;
  localparam logic [5:0] OutBase0 = 6'd42;
  localparam logic [5:0] OutBase1 = 6'd50;
  localparam logic [7:0] PllRstA  = 8'h20;
  localparam logic [7:0] PllRstB  = 8'h80;
  localparam logic [7:0] ClkCtrl0 = 8'h4F;
  localparam logic [7:0] ClkCtrl1 = 8'h6F;
  localparam logic [3:0] DivBy4   = 4'hC;

  // sideband carried through the output divider quotient
  typedef struct packed {
    logic [1:0]  ch;
    logic [27:0] freq;
    logic [2:0]  rdiv;
    logic        badch;
    logic        zero;
  } side1_t;

  // sideband carried through the pll ratio quotient
  typedef struct packed {
    logic [7:0] div8;
    logic       ch;
    logic [2:0] rdiv;
    logic [1:0] status;
  } side2_t;

  // multisynth parameter packing into eight bytes, first byte on top
  function automatic logic [63:0] pack_ms(input logic [17:0] p1, input logic [19:0] p2,
                                          input logic [19:0] p3);
    pack_ms = {p3[15:8], p3[7:0], 6'd0, p1[17:16], p1[15:8], p1[7:0],
               p3[19:16], p2[19:16], p2[15:8], p2[7:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csdp_pipe_div.sv =====
// restoring divider, one quotient bit per pipeline stage
`default_nettype none

module csdp_pipe_div #(
  parameter int NumW  = 30,
  parameter int DenW  = 28,
  parameter int QuoW  = 30,
  parameter int SideW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  input  wire logic [SideW-1:0] side,
  output logic                  out_valid,
  output logic [QuoW-1:0]       quo,
  output logic [SideW-1:0]      side_out
);

  logic             vld_r  [NumW+1];
  logic [DenW-1:0]  rem_r  [NumW+1];
  logic [NumW-1:0]  num_r  [NumW+1];
  logic [DenW-1:0]  den_r  [NumW+1];
  logic [QuoW-1:0]  quo_r  [NumW+1];
  logic [SideW-1:0] side_r [NumW+1];

  // stage zero is the incoming word
  assign vld_r[0]  = in_valid;
  assign rem_r[0]  = '0;
  assign num_r[0]  = num;
  assign den_r[0]  = den;
  assign quo_r[0]  = '0;
  assign side_r[0] = side;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    // shift in next dividend bit and try to subtract
    always_comb begin
      trial = {rem_r[k], num_r[k][NumW-1]};
      diff  = trial - {1'b0, den_r[k]};
      ge    = trial >= {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        num_r[k+1]  <= {num_r[k][NumW-2:0], 1'b0};
        den_r[k+1]  <= den_r[k];
        quo_r[k+1]  <= {quo_r[k][QuoW-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[NumW];
  assign quo       = quo_r[NumW];
  assign side_out  = side_r[NumW];

endmodule

`default_nettype wire

// ===== hw/rtl/clock_synth_divider_planner.sv =====
// Clock synthesizer divider planner: turns a channel and a target frequency into
// pll and output multisynth register images. Fully pipelined: one word is taken
// every cycle while the output side keeps up. A word passes through 30 stages for the
// output divider quotient, 57 for the pll ratio quotient, each one bit per stage,
// and five stages of range check, rounding, fraction, vco product and packing.
// A stall at the output holds the whole pipeline.
// Configuration must only change while no word is in flight.
`default_nettype none

module clock_synth_divider_planner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [29:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  channel,
  input  wire logic [27:0] target_hz,
  input  wire logic [2:0]  rdiv_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      pll_regs,
  output logic [63:0]      out_regs,
  output logic [5:0]       pll_base_addr,
  output logic [5:0]       out_base_addr,
  output logic [7:0]       pll_reset_byte,
  output logic [7:0]       clk_ctrl_byte,
  output logic [29:0]      vco_hz,
  output logic [1:0]       status
);

  import csdp_pkg::*;

  localparam int Side1W = $bits(side1_t);
  localparam int Side2W = $bits(side2_t);

  logic [25:0] xtal_hz;
  logic [29:0] vco_target_hz;
  logic        adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      xtal_hz       <= 26'd25000000;
      vco_target_hz <= 30'd900000000;
    end else if (cfg_we) begin
      if (cfg_index == RegXtal) begin
        xtal_hz <= cfg_data[25:0];
      end
      if (cfg_index == RegVco) begin
        vco_target_hz <= cfg_data;
      end
    end
  end

  // whole pipeline moves when the output register is empty or its word is being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // output divider quotient
  side1_t      s1_in;
  side1_t      s1_out;
  logic [Side1W-1:0] s1_vec;
  logic        d1_valid;
  logic [29:0] d1_quo;

  always_comb begin
    s1_in.ch    = channel;
    s1_in.freq  = target_hz;
    s1_in.rdiv  = rdiv_code;
    s1_in.badch = channel[1];
    s1_in.zero  = (target_hz == '0) || (xtal_hz == '0) || (vco_target_hz == '0);
  end

  csdp_pipe_div #(
    .NumW(30), .DenW(28), .QuoW(30), .SideW(Side1W)
  ) u_div_out (
    .clk, .rst, .adv,
    .in_valid (in_valid && in_ready),
    .num      (vco_target_hz),
    .den      (target_hz),
    .side     (Side1W'(s1_in)),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .side_out (s1_vec)
  );

  assign s1_out = side1_t'(s1_vec);

  // range check and wanted vco
  logic [29:0] div_even;
  logic        div_bad;
  logic        b_valid;
  logic [35:0] b_want;
  side2_t      b_side;

  always_comb begin
    div_even = {d1_quo[29:1], 1'b0};
    div_bad  = (div_even[29:8] != '0) || (div_even[7:0] < 8'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_want      <= 36'(s1_out.freq) * 36'(div_even[7:0]);
      b_side.div8 <= div_even[7:0];
      b_side.ch   <= s1_out.ch[0];
      b_side.rdiv <= s1_out.rdiv;
      if (s1_out.badch) begin
        b_side.status <= StatusBadChan;
      end else if (s1_out.zero || div_bad) begin
        b_side.status <= StatusBadDiv;
      end else begin
        b_side.status <= StatusOk;
      end
    end
  end

  // pll ratio quotient, low 29 bits kept
  logic              d2_valid;
  logic [28:0]       d2_quo;
  logic [Side2W-1:0] s2_vec;
  side2_t            s2_out;

  csdp_pipe_div #(
    .NumW(57), .DenW(26), .QuoW(29), .SideW(Side2W)
  ) u_div_ratio (
    .clk, .rst, .adv,
    .in_valid (b_valid),
    .num      ({b_want, 21'd0}),
    .den      (xtal_hz),
    .side     (Side2W'(b_side)),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .side_out (s2_vec)
  );

  assign s2_out = side2_t'(s2_vec);

  // integer part and rounded fraction
  logic        c_valid;
  logic [7:0]  c_a;
  logic [20:0] c_b;
  side2_t      c_side;
  logic [21:0] b_round;

  assign b_round = {1'b0, d2_quo[20:0]} + 22'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_a    <= d2_quo[28:21];
      c_b    <= b_round[21:1];
      c_side <= s2_out;
    end
  end

  // divisions by the fractional denominator and p1/p2
  logic [7:0]  q0;
  logic [20:0] r0;
  logic        r_ge;
  logic [7:0]  f128;
  logic [20:0] r_sub;
  logic [20:0] frac;
  logic        d_valid;
  logic [17:0] d_p1;
  logic [19:0] d_p2;
  logic [28:0] d_sum;
  side2_t      d_side;

  always_comb begin
    q0    = c_b[20:13];
    r0    = {1'b0, c_b[12:0], 7'd0} + {13'd0, q0};
    r_ge  = r0 >= {1'b0, FracDen};
    f128  = q0 + {7'd0, r_ge};
    r_sub = r0 - {1'b0, FracDen};
    frac  = c_b + {20'd0, (c_b >= {1'b0, FracDen})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_p1   <= {3'd0, c_a, 7'd0} + {10'd0, f128} - 18'd512;
      d_p2   <= r_ge ? r_sub[19:0] : r0[19:0];
      d_sum  <= {1'b0, c_a, 20'd0} + {8'd0, frac};
      d_side <= c_side;
    end
  end

  // vco product
  logic        e_valid;
  logic [54:0] e_prod;
  logic [17:0] e_p1;
  logic [19:0] e_p2;
  side2_t      e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod <= 55'(xtal_hz) * 55'(d_sum);
      e_p1   <= d_p1;
      e_p2   <= d_p2;
      e_side <= d_side;
    end
  end

  // final packing into the output register
  logic [55:0] vco_round;
  logic [17:0] out_p1;
  logic [63:0] out_img;
  logic        ok;

  always_comb begin
    vco_round = {1'b0, e_prod} + 56'd524288;
    out_p1    = {3'd0, e_side.div8, 7'd0} - 18'd512;
    out_img   = pack_ms(out_p1, 20'd0, 20'd1);
    out_img[46:44] = out_img[46:44] | e_side.rdiv;
    if (e_side.div8 == 8'd4) begin
      out_img[43:40] = out_img[43:40] | DivBy4;
    end
    ok = e_side.status == StatusOk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status         <= e_side.status;
      pll_regs       <= ok ? pack_ms(e_p1, e_p2, {FracDen}) : '0;
      out_regs       <= ok ? out_img : '0;
      pll_base_addr  <= ok ? (e_side.ch ? PllBaseB : PllBaseA) : '0;
      out_base_addr  <= ok ? (e_side.ch ? OutBase1 : OutBase0) : '0;
      pll_reset_byte <= ok ? (e_side.ch ? PllRstB : PllRstA) : '0;
      clk_ctrl_byte  <= ok ? (e_side.ch ? ClkCtrl1 : ClkCtrl0) : '0;
      vco_hz         <= ok ? vco_round[49:20] : '0;
    end
  end

  // a rejected word carries nothing but its status
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != StatusOk |-> pll_regs == '0 && out_regs == '0 && vco_hz == '0)
    else $error("rejected word has nonzero payload");

  // an accepted plan always carries the fixed pll denominator bytes
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == StatusOk |-> pll_regs[63:48] == 16'hFFFF && pll_regs[23:20] == 4'hF)
    else $error("pll denominator bytes wrong");

  // addresses follow the same channel as the control bytes
  a_ok_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == StatusOk |->
      (pll_base_addr == PllBaseB) == (clk_ctrl_byte == ClkCtrl1))
    else $error("channel constants disagree");

  // a stalled output holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pll_regs) && $stable(status))
    else $error("stalled word changed");

endmodule

`default_nettype wire

// ===== tb/sv/clock_synth_divider_planner_tb.sv =====
// testbench for the clock synthesizer divider planner: directed and random words, scoreboard
`timescale 1ns / 100ps

module clock_synth_divider_planner_tb;
  import csdp_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 120;

  // one expected or observed result word
  typedef struct packed {
    logic [63:0] pll_regs;
    logic [63:0] out_regs;
    logic [5:0]  pll_base;
    logic [5:0]  out_base;
    logic [7:0]  pll_rst;
    logic [7:0]  clk_ctrl;
    logic [29:0] vco;
    logic [1:0]  stat;
  } plan_t;

  // scoreboard: own copy of the registers, expected plans in arrival order
  class divider_plan_board;
    logic [25:0] xtal;
    logic [29:0] vco_tgt;
    plan_t plans_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned ok_plans;

    function new();
      xtal = 26'd25000000;
      vco_tgt = 30'd900000000;
      mismatches = 0;
      checked = 0;
      ok_plans = 0;
    endfunction

    function void set_reg(logic idx, logic [29:0] val);
      if (idx == RegXtal) xtal = val[25:0];
      else vco_tgt = val;
    endfunction

    // eight-byte multisynth image, first byte on top
    function logic [63:0] ms_image(logic [17:0] p1, logic [19:0] p2, logic [19:0] p3);
      logic [63:0] r;
      r = 64'd0;
      r[63:48] = p3[15:0];
      r[41:24] = p1;
      r[23:20] = p3[19:16];
      r[19:0] = p2;
      return r;
    endfunction

    function plan_t plan_for(logic [1:0] ch, logic [27:0] hz, logic [2:0] rd);
      plan_t p;
      longint unsigned dv, want, ratio, a, b, f128, frac, v, den;
      logic [17:0] p1;
      logic [19:0] p2;
      p = '0;
      den = FracDen;
      if (ch > 2'd1) begin
        p.stat = StatusBadChan;
        return p;
      end
      if (hz == 0 || xtal == 0 || vco_tgt == 0) begin
        p.stat = StatusBadDiv;
        return p;
      end
      dv = (64'(vco_tgt) / 64'(hz)) & ~64'd1;
      if (dv < 4 || dv > 254) begin
        p.stat = StatusBadDiv;
        return p;
      end
      want = 64'(hz) * dv;
      ratio = (want << 21) / 64'(xtal);
      a = (ratio >> 21) & 64'hFF;
      b = ((ratio & 64'h1FFFFF) + 1) >> 1;
      f128 = (b << 7) / den;
      p1 = 18'((a << 7) + f128 - 512);
      p2 = 20'((b << 7) - den * f128);
      p.pll_regs = ms_image(p1, p2, FracDen);
      p.out_regs = ms_image(18'((dv << 7) - 512), 20'd0, 20'd1);
      p.out_regs[46:44] = p.out_regs[46:44] | rd;
      if (dv == 4) p.out_regs[43:40] = p.out_regs[43:40] | DivBy4;
      frac = (b << 20) / den;
      v = (64'(xtal) * (frac + (a << 20)) + (64'd1 << 19)) >> 20;
      p.vco = v[29:0];
      p.pll_base = ch[0] ? PllBaseB : PllBaseA;
      p.out_base = ch[0] ? OutBase1 : OutBase0;
      p.pll_rst = ch[0] ? PllRstB : PllRstA;
      p.clk_ctrl = ch[0] ? ClkCtrl1 : ClkCtrl0;
      p.stat = StatusOk;
      return p;
    endfunction

    function void note_request(logic [1:0] ch, logic [27:0] hz, logic [2:0] rd);
      plans_due.push_back(plan_for(ch, hz, rd));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch %0s: got %h expected %h", what, got, want);
    endtask

    task check_plan(plan_t got);
      plan_t e;
      checked++;
      if (plans_due.size() == 0) begin
        report("unexpected word", 64'(got.stat), 64'd0);
        return;
      end
      e = plans_due.pop_front();
      if (e.stat == StatusOk) ok_plans++;
      if (got.pll_regs !== e.pll_regs) report("pll_regs", got.pll_regs, e.pll_regs);
      if (got.out_regs !== e.out_regs) report("out_regs", got.out_regs, e.out_regs);
      if (got.pll_base !== e.pll_base) report("pll_base_addr", 64'(got.pll_base), 64'(e.pll_base));
      if (got.out_base !== e.out_base) report("out_base_addr", 64'(got.out_base), 64'(e.out_base));
      if (got.pll_rst !== e.pll_rst) report("pll_reset_byte", 64'(got.pll_rst), 64'(e.pll_rst));
      if (got.clk_ctrl !== e.clk_ctrl) report("clk_ctrl_byte", 64'(got.clk_ctrl), 64'(e.clk_ctrl));
      if (got.vco !== e.vco) report("vco_hz", 64'(got.vco), 64'(e.vco));
      if (got.stat !== e.stat) report("status", 64'(got.stat), 64'(e.stat));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [29:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  channel = '0;
  logic [27:0] target_hz = '0;
  logic [2:0]  rdiv_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] pll_regs, out_regs;
  logic [5:0]  pll_base_addr, out_base_addr;
  logic [7:0]  pll_reset_byte, clk_ctrl_byte;
  logic [29:0] vco_hz;
  logic [1:0]  status;

  divider_plan_board board = new();
  bit no_idle = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned phases = 0;

  clock_synth_divider_planner dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .channel(channel), .target_hz(target_hz),
    .rdiv_code(rdiv_code), .out_valid(out_valid), .out_ready(out_ready),
    .pll_regs(pll_regs), .out_regs(out_regs), .pll_base_addr(pll_base_addr),
    .out_base_addr(out_base_addr), .pll_reset_byte(pll_reset_byte),
    .clk_ctrl_byte(clk_ctrl_byte), .vco_hz(vco_hz), .status(status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_plan({pll_regs, out_regs, pll_base_addr, out_base_addr,
                        pll_reset_byte, clk_ctrl_byte, vco_hz, status});
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d words outstanding", board.plans_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls, drawn per word
  initial begin : receiver
    int unsigned stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request word, with a random gap before it
  task send_word(logic [1:0] ch, logic [27:0] hz, logic [2:0] rd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    target_hz <= hz;
    rdiv_code <= rd;
    do @(posedge clk); while (!in_ready);
    board.note_request(ch, hz, rd);
    sent++;
  endtask

  // drain the pipeline before touching the registers
  task drain;
    in_valid <= 1'b0;
    while (board.plans_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [29:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // mostly targets near a valid divider, some raw noise and bad channels
  task random_words(int unsigned count);
    logic [1:0] ch;
    logic [27:0] hz;
    int unsigned pick, d;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      if (pick < 75) begin
        d = $urandom_range(3, 260);
        hz = 28'(board.vco_tgt / d + $urandom_range(0, 2000) - 1000);
      end else if (pick < 95) begin
        hz = 28'($urandom);
      end else begin
        hz = 28'($urandom_range(0, 8));
      end
      send_word(ch, hz, 3'($urandom_range(0, 7)));
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: channels, field extremes, divider edges, r codes
    send_word(2'd0, 28'd225000000, 3'd0);
    send_word(2'd1, 28'd225000000, 3'd7);
    send_word(2'd2, 28'd10000000, 3'd1);
    send_word(2'd3, 28'd10000000, 3'd2);
    send_word(2'd0, 28'd0, 3'd3);
    send_word(2'd1, 28'd1, 3'd4);
    send_word(2'd0, 28'hFFFFFFF, 3'd5);
    send_word(2'd1, 28'd3543307, 3'd6);
    send_word(2'd0, 28'd3515625, 3'd7);
    send_word(2'd1, 28'd3515626, 3'd0);
    send_word(2'd0, 28'd3529412, 3'd1);
    send_word(2'd1, 28'd150000000, 3'd2);
    send_word(2'd0, 28'd12345678, 3'd3);
    send_word(2'd1, 28'd100000000, 3'd4);
    send_word(2'd0, 28'd180000000, 3'd5);
    send_word(2'd1, 28'd7000000, 3'd6);
    random_words(280);
    phases++;

    // register settings, extremes first
    drain();
    write_reg(RegXtal, 30'd10000000);
    write_reg(RegVco, 30'd600000000);
    random_words(270);
    phases++;
    drain();
    write_reg(RegXtal, 30'd40000000);
    write_reg(RegVco, 30'd900000000);
    random_words(270);
    phases++;
    drain();
    write_reg(RegVco, 30'd600000000);
    random_words(270);
    phases++;
    drain();
    write_reg(RegXtal, 30'($urandom_range(10000000, 40000000)));
    write_reg(RegVco, 30'($urandom_range(600000000, 900000000)));
    random_words(270);
    phases++;
    // zero crystal and a crystal small enough to overflow the integer part
    drain();
    write_reg(RegXtal, 30'd0);
    random_words(20);
    drain();
    write_reg(RegXtal, 30'd1000000);
    write_reg(RegVco, 30'h3FFFFFFF);
    random_words(60);
    phases += 2;
    drain();
    write_reg(RegXtal, 30'd25000000);
    write_reg(RegVco, 30'd900000000);
    random_words(200);
    phases++;

    drain();
    $display("sent %0d requests over %0d register settings, %0d results checked",
             sent, phases, board.checked);
    $display("%0d results had a valid divider, %0d mismatches", board.ok_plans,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
